@@ hw/rtl/cig_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cig_pkg: shared constants and types for the ECG low-pass filter
// Filter geometry, field widths, command codes and the integrator item type.
// ----------------------------------------------------------------------------
package cig_pkg;

  localparam int LEADS      = 8;
  localparam int BUF_SIZE   = 13;
  localparam int DIVISOR    = 36;
  localparam int HALF_DELAY = (BUF_SIZE - 1) / 2;

  localparam int LeadW   = 3;
  localparam int SampleW = 24;
  localparam int FiltW   = 25;
  localparam int AccW    = 32;
  localparam int PosW    = $clog2(BUF_SIZE);
  localparam int Depth   = LEADS * BUF_SIZE;
  localparam int AddrW   = $clog2(Depth);

  typedef enum logic {
    CmdFilter = 1'b0,
    CmdClear  = 1'b1
  } cmd_e;

  // integrator output heading into the divider
  typedef struct packed {
    logic [LeadW-1:0] lead;
    logic [AccW-1:0]  y;
  } cig_item_t;

endpackage

@@ hw/rtl/cig_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cig_ram: generic RAM, one write port and two registered read ports
// Read data updates only on a read enable and holds otherwise.
// ----------------------------------------------------------------------------
module cig_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

@@ hw/rtl/cig_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cig_div: signed divide by DIVISOR, truncated toward zero
// Magnitude times reciprocal, one remainder correction, then sign restore.
// ----------------------------------------------------------------------------
module cig_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  cig_pkg::cig_item_t           item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [cig_pkg::LeadW-1:0]    out_lead_o,
  output logic signed [cig_pkg::FiltW-1:0] filtered_o
);
  import cig_pkg::*;

  localparam int RecipW = AccW + 1;
  localparam int ProdW  = AccW + RecipW;
  // floor(2^32 / D): estimate is low by at most one
  localparam logic [RecipW-1:0] Recip = RecipW'((65'd1 << AccW) / DIVISOR);

  // stage 1: magnitude
  logic             d1_vld_q;
  logic [LeadW-1:0] d1_lead_q;
  logic             d1_neg_q;
  logic [AccW-1:0]  d1_mag_q;
  // stage 2: reciprocal product
  logic             d2_vld_q;
  logic [LeadW-1:0] d2_lead_q;
  logic             d2_neg_q;
  logic [AccW-1:0]  d2_mag_q;
  logic [ProdW-1:0] d2_prod_q;
  // stage 3: quotient estimate and remainder
  logic             d3_vld_q;
  logic [LeadW-1:0] d3_lead_q;
  logic             d3_neg_q;
  logic [AccW-1:0]  d3_qe_q;
  logic [AccW-1:0]  d3_rem_q;

  logic out_free, d3_free, d2_free, d1_free;
  logic [AccW-1:0] qd, rem_d, q_fix, q_sgn;
  logic            corr;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign d3_free    = !d3_vld_q || out_free;
  assign d2_free    = !d2_vld_q || d3_free;
  assign d1_free    = !d1_vld_q || d2_free;
  assign in_stall_o = !d1_free;

  always_comb begin
    qd    = d2_prod_q[ProdW-2:AccW] * AccW'(DIVISOR);
    rem_d = d2_mag_q - qd;
    corr  = d3_rem_q >= AccW'(DIVISOR);
    q_fix = d3_qe_q + AccW'(corr);
    q_sgn = d3_neg_q ? (~q_fix + AccW'(1)) : q_fix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_vld_q    <= 1'b0;
      d2_vld_q    <= 1'b0;
      d3_vld_q    <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (d1_free)  d1_vld_q    <= in_valid_i;
      if (d2_free)  d2_vld_q    <= d1_vld_q;
      if (d3_free)  d3_vld_q    <= d2_vld_q;
      if (out_free) out_valid_o <= d3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d1_free && in_valid_i) begin
      d1_lead_q <= item_i.lead;
      d1_neg_q  <= item_i.y[AccW-1];
      d1_mag_q  <= item_i.y[AccW-1] ? (~item_i.y + AccW'(1)) : item_i.y;
    end
    if (d2_free && d1_vld_q) begin
      d2_lead_q <= d1_lead_q;
      d2_neg_q  <= d1_neg_q;
      d2_mag_q  <= d1_mag_q;
      d2_prod_q <= ProdW'(d1_mag_q) * ProdW'(Recip);
    end
    if (d3_free && d2_vld_q) begin
      d3_lead_q <= d2_lead_q;
      d3_neg_q  <= d2_neg_q;
      d3_qe_q   <= d2_prod_q[ProdW-2:AccW];
      d3_rem_q  <= rem_d;
    end
    if (out_free && d3_vld_q) begin
      out_lead_o <= d3_lead_q;
      filtered_o <= q_sgn[FiltW-1:0];
    end
  end

  // estimate never falls short by more than one divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d3_vld_q |-> d3_rem_q < AccW'(2 * DIVISOR))
    else $error("divider remainder out of correction range");

  // product top bit is never set, quotient fits the accumulator
  a_prod_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d2_vld_q |-> !d2_prod_q[ProdW-1])
    else $error("reciprocal product overflow");

  // a stalled result holds steady
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_lead_o) && $stable(filtered_o)))
    else $error("stalled result changed");

endmodule

@@ hw/rtl/comb_integrator_ecg_lowpass.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comb_integrator_ecg_lowpass: multichannel integer ECG low-pass filter
// Per-lead y = 2*y1 - y2 + x - 2*x[n-H] + x[n-2H], result y / DIVISOR.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request per cycle while not stalled:
//   a sample for a lead (cmd_i = filter) or a clear of that lead's state
//   (cmd_i = clear). A clear returns nothing; a lead at or above LEADS is
//   dropped.
//   Output channel (out_valid_o / out_stall_i) carries out_lead_o and
//   filtered_o, one request per filtered sample, in input order.
//   Throughput: one request per cycle while in_stall_o is low, for any mix of leads. The per-lead
//   integrator and ring pointer are each updated in one step, and the
//   history RAM gives two registered reads plus one write each cycle.
//   Path: the RAM read lands at the accepting edge in stage 1, then the
//   result passes the integrator register and four divider stages.
//   Stall: each stage holds only while the next is full, so bubbles close
//   up and requests keep entering while a result waits; in_stall_o rises
//   once the pipeline is full behind a stalled output.
//   Reset: all lead state reads as zero at once; history entries carry a
//   valid bit each, so no clearing pass is needed. A clear does the same
//   for its lead.
// ----------------------------------------------------------------------------
module comb_integrator_ecg_lowpass (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic [cig_pkg::LeadW-1:0]         lead_i,
  input  logic signed [cig_pkg::SampleW-1:0] sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [cig_pkg::LeadW-1:0]         out_lead_o,
  output logic signed [cig_pkg::FiltW-1:0]  filtered_o
);
  import cig_pkg::*;

  // ring address of a lead's slot
  function automatic logic [AddrW-1:0] ring_addr(input logic [LeadW-1:0] ld,
                                                 input logic [PosW-1:0]  pos);
    ring_addr = AddrW'(ld) * AddrW'(BUF_SIZE) + AddrW'(pos);
  endfunction

  // (pos + off) mod BUF_SIZE, off below BUF_SIZE
  function automatic logic [PosW-1:0] ring_step(input logic [PosW-1:0] pos,
                                                input int              off);
    logic [PosW:0] s;
    s = (PosW+1)'(pos) + (PosW+1)'(off);
    if (s >= (PosW+1)'(BUF_SIZE)) begin
      s = s - (PosW+1)'(BUF_SIZE);
    end
    ring_step = s[PosW-1:0];
  endfunction

  function automatic logic [AccW-1:0] sext(input logic [SampleW-1:0] v);
    sext = {{(AccW-SampleW){v[SampleW-1]}}, v};
  endfunction

  // ---- per-lead state ----
  logic [PosW-1:0] wp_q     [LEADS];
  logic [AccW-1:0] integ_q  [LEADS];  // y1
  logic [AccW-1:0] integ2_q [LEADS];  // y2
  logic [Depth-1:0] hvld_q;           // history entry written since clear

  // ---- front end ----
  logic             lead_ok, in_acc, smp_acc, clr_acc;
  logic [PosW-1:0]  wp_cur, pos_h, pos_2h;
  logic [AddrW-1:0] waddr, raddr_h, raddr_2h;

  // ---- stage 1: RAM data ----
  logic               s1_vld_q;
  logic [LeadW-1:0]   s1_lead_q;
  logic [SampleW-1:0] s1_x_q;
  logic               s1_hv_q, s1_2v_q;
  logic [SampleW-1:0] rd_h, rd_2h;

  // ---- stage 2: integrator output ----
  logic      s2_vld_q;
  cig_item_t s2_item_q;

  logic            div_stall, s2_free, s1_free, s1_adv;
  logic [AccW-1:0] xh, x2h, y1, y2, y_d;

  assign lead_ok  = 32'(lead_i) < LEADS;
  assign s2_free  = !s2_vld_q || !div_stall;
  assign s1_free  = !s1_vld_q || s2_free;
  assign s1_adv   = s1_vld_q && s2_free;
  assign in_stall_o = !s1_free;
  assign in_acc   = in_valid_i && s1_free;
  assign smp_acc  = in_acc && lead_ok && (cmd_i == CmdFilter);
  assign clr_acc  = in_acc && lead_ok && (cmd_i == CmdClear);

  assign wp_cur   = wp_q[lead_i];
  assign pos_h    = ring_step(wp_cur, HALF_DELAY);
  assign pos_2h   = ring_step(wp_cur, 2 * HALF_DELAY);
  assign waddr    = ring_addr(lead_i, wp_cur);
  assign raddr_h  = ring_addr(lead_i, pos_h);
  assign raddr_2h = ring_addr(lead_i, pos_2h);

  cig_ram #(
    .Width (SampleW),
    .Depth (Depth)
  ) u_hist (
    .clk_i     (clk_i),
    .we_i      (smp_acc),
    .waddr_i   (waddr),
    .wdata_i   (sample_i),
    .re_i      (smp_acc),
    .raddr_a_i (raddr_h),
    .raddr_b_i (raddr_2h),
    .rdata_a_o (rd_h),
    .rdata_b_o (rd_2h)
  );

  // entry valid bits: set on write, dropped by a clear of the owning lead
  for (genvar g = 0; g < Depth; g++) begin : g_hvld
    localparam logic [LeadW-1:0] EntryLead = LeadW'(g / BUF_SIZE);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hvld_q[g] <= 1'b0;
      end else if (clr_acc && lead_i == EntryLead) begin
        hvld_q[g] <= 1'b0;
      end else if (smp_acc && waddr == AddrW'(g)) begin
        hvld_q[g] <= 1'b1;
      end
    end
  end

  // ring pointer moves down one slot per sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEADS; i++) begin
        wp_q[i] <= '0;
      end
    end else if (clr_acc) begin
      wp_q[lead_i] <= '0;
    end else if (smp_acc) begin
      wp_q[lead_i] <= (wp_cur == '0) ? PosW'(BUF_SIZE - 1) : wp_cur - PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_free) begin
      s1_vld_q <= smp_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      s1_lead_q <= lead_i;
      s1_x_q    <= sample_i;
      s1_hv_q   <= hvld_q[raddr_h];
      s1_2v_q   <= hvld_q[raddr_2h];
    end
  end

  // integrator, wraps mod 2^32
  always_comb begin
    xh  = s1_hv_q ? sext(rd_h)  : '0;
    x2h = s1_2v_q ? sext(rd_2h) : '0;
    y1  = integ_q[s1_lead_q];
    y2  = integ2_q[s1_lead_q];
    y_d = (y1 << 1) - y2 + sext(s1_x_q) - (xh << 1) + x2h;
  end

  // a clear taken in the same cycle lands after the shift and wins
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEADS; i++) begin
        integ_q[i]  <= '0;
        integ2_q[i] <= '0;
      end
    end else begin
      if (s1_adv) begin
        integ2_q[s1_lead_q] <= y1;
        integ_q[s1_lead_q]  <= y_d;
      end
      if (clr_acc) begin
        integ2_q[lead_i] <= '0;
        integ_q[lead_i]  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_free) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_item_q.lead <= s1_lead_q;
      s2_item_q.y    <= y_d;
    end
  end

  cig_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_vld_q),
    .in_stall_o  (div_stall),
    .item_i      (s2_item_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_lead_o  (out_lead_o),
    .filtered_o  (filtered_o)
  );

  // ring pointer stays inside the buffer
  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q[lead_i] < PosW'(BUF_SIZE))
    else $error("ring pointer out of range");

  // an accepted sample always reaches stage 1
  a_smp_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_acc |=> s1_vld_q)
    else $error("accepted sample lost before integrator");

  // a clear leaves the lead's integrator and pointer at zero
  a_clr_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_acc |=> (integ_q[$past(lead_i)] == '0) && (integ2_q[$past(lead_i)] == '0)
                && (wp_q[$past(lead_i)] == '0))
    else $error("clear did not reset lead state");

  // a held stage 1 keeps its item
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !s2_free) |=> (s1_vld_q && $stable(s1_lead_q) && $stable(s1_x_q)))
    else $error("stage 1 changed while held");

endmodule
